// ===== rtl/pslt_pkg.sv =====
`timescale 1ns / 1ps
package pslt_pkg;

  // operation codes of an input word
  localparam logic [2:0] OP_SEND   = 3'd0;
  localparam logic [2:0] OP_RECV   = 3'd1;
  localparam logic [2:0] OP_LOG    = 3'd2;
  localparam logic [2:0] OP_CLOSE  = 3'd3;
  localparam logic [2:0] OP_FINISH = 3'd4;

  // result kinds
  localparam logic [3:0] KIND_FRESH_SEND = 4'd0;
  localparam logic [3:0] KIND_SEND_LOSS  = 4'd1;
  localparam logic [3:0] KIND_FIRST_RECV = 4'd2;
  localparam logic [3:0] KIND_DUPLICATE  = 4'd3;
  localparam logic [3:0] KIND_UNEXPECTED = 4'd4;
  localparam logic [3:0] KIND_STALE      = 4'd5;
  localparam logic [3:0] KIND_LOGGED     = 4'd6;
  localparam logic [3:0] KIND_WINDOW     = 4'd7;
  localparam logic [3:0] KIND_FINAL      = 4'd8;

  // counter positions
  localparam int N_CNT       = 7;
  localparam int CNT_SENT    = 0;
  localparam int CNT_UNIQUE  = 1;
  localparam int CNT_RECV    = 2;
  localparam int CNT_REORDER = 3;
  localparam int CNT_LOST    = 4;
  localparam int CNT_DUP     = 5;
  localparam int CNT_UNEXP   = 6;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] seq;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic        reordered;
    logic [31:0] sent_count;
    logic [31:0] unique_count;
    logic [31:0] received_count;
    logic [31:0] reorder_count;
    logic [31:0] lost_count;
    logic [31:0] duplicate_count;
    logic [31:0] unexpected_count;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture the accepted word
    logic       clr_wr;    // write an empty slot at the sweep pointer
    logic       mod_step;  // advance the slot index reduction
    logic       rd_en;     // read the slot of the captured number
    logic       sweep_rd;  // read the slot at the sweep pointer
    logic       exec;      // apply the operation and emit the result
    logic [2:0] op;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic mod_last;
    logic pow2;
  } dp_stat_t;

endpackage

// ===== rtl/pslt_ctrl.sv =====
`timescale 1ns / 1ps
module pslt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        in_op,
  input  pslt_pkg::dp_stat_t stat,
  output logic              busy,
  output pslt_pkg::ctl_cmd_t cmd
);
  import pslt_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);

  // sequence the steps of one word
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    cmd          = '0;
    cmd.op       = op_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          op_nxt   = in_op;
          priority if (in_op == OP_SEND || in_op == OP_RECV) begin
            state_nxt = stat.pow2 ? S_READ : S_MOD;
          end else if (in_op == OP_LOG || in_op == OP_CLOSE) begin
            state_nxt = S_EXEC;
          end else if (in_op == OP_FINISH) begin
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // last swept slot is retired in this cycle
        state_nxt = S_EXEC;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      op_r    <= OP_SEND;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

// ===== rtl/pslt_dp.sv =====
`timescale 1ns / 1ps
module pslt_dp #(
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pslt_pkg::ctl_cmd_t cmd,
  input  pslt_pkg::in_word_t in_word,
  output pslt_pkg::dp_stat_t stat,
  output logic               out_valid,
  output pslt_pkg::out_word_t out_word
);
  import pslt_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int R_W   = IDX_W + 1;
  localparam bit IS_POW2 = ((QUEUE_DEPTH & (QUEUE_DEPTH - 1)) == 0);
  localparam logic [31:0]      IDX_MASK = 32'(QUEUE_DEPTH - 1);
  localparam logic [R_W-1:0]   DEPTH_R  = R_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam int MOD_BITS  = 8;
  localparam int MOD_STEPS = 32 / MOD_BITS;
  localparam logic [1:0] MOD_LAST = 2'(MOD_STEPS - 1);

  typedef struct packed {
    logic        valid;
    logic        answered;
    logic [31:0] seq;
  } slot_t;

  // slot ring
  slot_t mem [QUEUE_DEPTH];
  slot_t mem_q_r;

  logic [31:0]      seq_r;
  logic [31:0]      sh_r;
  logic [R_W-1:0]   rem_r, rem_nxt;
  logic [1:0]       mod_cnt_r;
  logic [IDX_W-1:0] sweep_r;
  logic             pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic [31:0]      high_r, high_nxt;
  logic [31:0]      total_r  [N_CNT];
  logic [31:0]      window_r [N_CNT];
  logic [31:0]      total_nxt [N_CNT];
  logic [31:0]      window_nxt [N_CNT];
  logic [N_CNT-1:0] bump;
  logic [3:0]       kind;
  logic             reo;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_addr;
  logic             out_valid_r;
  out_word_t        out_word_r;

  assign stat.sweep_last = (sweep_r == LAST_IDX);
  assign stat.mod_last   = (mod_cnt_r == MOD_LAST);
  assign stat.pow2       = IS_POW2;

  // slot index of the captured number
  assign idx = IS_POW2 ? IDX_W'((seq_r - 32'd1) & IDX_MASK) : rem_r[IDX_W-1:0];

  // reduce eight bits per step, most significant first
  always_comb begin
    logic [R_W-1:0] t;
    t = rem_r;
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {t[R_W-2:0], sh_r[31-i]};
      if (t >= DEPTH_R) begin
        t = t - DEPTH_R;
      end
    end
    rem_nxt = t;
  end

  // decide the outcome and the slot update
  always_comb begin
    logic match;
    bump     = '0;
    kind     = KIND_FRESH_SEND;
    reo      = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_data  = '0;
    high_nxt = high_r;
    match    = mem_q_r.valid && (mem_q_r.seq == seq_r);
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = sweep_r;
    end else if (pend_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_idx_r;
      bump[CNT_LOST] = mem_q_r.valid && !mem_q_r.answered;
    end else if (cmd.exec) begin
      unique case (cmd.op)
        OP_SEND: begin
          bump[CNT_SENT] = 1'b1;
          if (mem_q_r.valid && !mem_q_r.answered) begin
            bump[CNT_LOST] = 1'b1;
            kind = KIND_SEND_LOSS;
          end
          wr_en   = 1'b1;
          wr_data = '{valid: 1'b1, answered: 1'b0, seq: seq_r};
        end
        OP_RECV: begin
          bump[CNT_RECV] = 1'b1;
          if (match) begin
            if (!mem_q_r.answered) begin
              bump[CNT_UNIQUE] = 1'b1;
              kind    = KIND_FIRST_RECV;
              wr_en   = 1'b1;
              wr_data = '{valid: 1'b1, answered: 1'b1, seq: seq_r};
            end else begin
              bump[CNT_DUP] = 1'b1;
              kind = KIND_DUPLICATE;
            end
            if (seq_r < high_r) begin
              bump[CNT_REORDER] = 1'b1;
              reo = 1'b1;
            end else begin
              high_nxt = seq_r;
            end
          end else if (!mem_q_r.valid || seq_r > mem_q_r.seq) begin
            bump[CNT_UNEXP] = 1'b1;
            kind = KIND_UNEXPECTED;
          end else begin
            kind = KIND_STALE;
          end
        end
        OP_LOG: begin
          bump[CNT_UNEXP] = 1'b1;
          kind = KIND_LOGGED;
        end
        OP_CLOSE: begin
          kind = KIND_WINDOW;
        end
        OP_FINISH: begin
          kind = KIND_FINAL;
        end
        default: begin
          kind = KIND_FRESH_SEND;
        end
      endcase
    end
  end

  // saturating counters; close window clears the window set
  always_comb begin
    for (int i = 0; i < N_CNT; i++) begin
      total_nxt[i]  = (bump[i] && total_r[i] != '1) ? total_r[i] + 32'd1 : total_r[i];
      window_nxt[i] = (bump[i] && window_r[i] != '1) ? window_r[i] + 32'd1 : window_r[i];
      if (cmd.exec && cmd.op == OP_CLOSE) begin
        window_nxt[i] = '0;
      end
    end
  end

  // capture the word and run the index reduction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r     <= in_word.seq;
      sh_r      <= in_word.seq - 32'd1;
      rem_r     <= '0;
      mod_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      sh_r      <= {sh_r[31-MOD_BITS:0], {MOD_BITS{1'b0}}};
      rem_r     <= rem_nxt;
      mod_cnt_r <= mod_cnt_r + 2'd1;
    end
  end

  // slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_addr = cmd.rd_en ? idx : sweep_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en || cmd.sweep_rd) begin
      mem_q_r <= mem[rd_addr];
    end
    pend_idx_r <= sweep_r;
  end

  // sweep pointer, pending sweep slot, counters, highest match
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      pend_r  <= 1'b0;
      high_r  <= '0;
      for (int i = 0; i < N_CNT; i++) begin
        total_r[i]  <= '0;
        window_r[i] <= '0;
      end
    end else begin
      if (cmd.clr_wr || cmd.sweep_rd) begin
        sweep_r <= stat.sweep_last ? '0 : sweep_r + IDX_W'(1);
      end
      pend_r <= cmd.sweep_rd;
      high_r <= high_nxt;
      for (int i = 0; i < N_CNT; i++) begin
        total_r[i]  <= total_nxt[i];
        window_r[i] <= window_nxt[i];
      end
    end
  end

  // result register; the valid strobe is high for one cycle per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_word_r.kind      <= kind;
      out_word_r.reordered <= reo;
      if (cmd.op == OP_CLOSE) begin
        out_word_r.sent_count       <= window_r[CNT_SENT];
        out_word_r.unique_count     <= window_r[CNT_UNIQUE];
        out_word_r.received_count   <= window_r[CNT_RECV];
        out_word_r.reorder_count    <= window_r[CNT_REORDER];
        out_word_r.lost_count       <= window_r[CNT_LOST];
        out_word_r.duplicate_count  <= window_r[CNT_DUP];
        out_word_r.unexpected_count <= window_r[CNT_UNEXP];
      end else begin
        out_word_r.sent_count       <= total_nxt[CNT_SENT];
        out_word_r.unique_count     <= total_nxt[CNT_UNIQUE];
        out_word_r.received_count   <= total_nxt[CNT_RECV];
        out_word_r.reorder_count    <= total_nxt[CNT_REORDER];
        out_word_r.lost_count       <= total_nxt[CNT_LOST];
        out_word_r.duplicate_count  <= total_nxt[CNT_DUP];
        out_word_r.unexpected_count <= total_nxt[CNT_UNEXP];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/packet_sequence_loss_tracker.sv =====
`timescale 1ns / 1ps
// Channel   Ports                       Direction  Transfer
// input     start, busy, in_word        in         start high while busy low
// result    out_valid, out_word         out        out_valid high for one cycle
//
// Send and receive pass through capture, slot read and update when QUEUE_DEPTH is a
// power of two; other depths add the slot index reduction before the slot read,
// eight bits per cycle. Log and close window pass through capture and update.
// Finish sweep walks the slot memory one slot a cycle, then emits its result.
// After reset a clearing pass empties every slot; busy is
// high meanwhile. The result appears in the cycle after the update and cannot be
// held off by the receiver.
module packet_sequence_loss_tracker #(
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pslt_pkg::in_word_t  in_word,
  output logic                out_valid,
  output pslt_pkg::out_word_t out_word
);
  import pslt_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  pslt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_word.op),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  pslt_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ===== bench/packet_sequence_loss_tracker_tb.sv =====
`timescale 1ns / 1ps
module packet_sequence_loss_tracker_tb;
  import pslt_pkg::*;

  localparam int DEPTH     = 1024;
  localparam int N_RANDOM  = 600;
  localparam int CYC_LIMIT = 400000;
  localparam int N_DIR     = 26;

  // one row of the directed part: word to send, and the kind when it is obvious
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] seq;
    logic        typed;
    logic [3:0]  kind;
    logic        reo;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  // predictor state
  logic [31:0] ring_seq [DEPTH];
  logic        ring_live [DEPTH];
  logic        ring_acked [DEPTH];
  logic [31:0] top_matched;
  logic [31:0] tot_cnt [N_CNT];
  logic [31:0] win_cnt [N_CNT];

  out_word_t   due_reports [$];
  out_word_t   want;
  dir_row_t    dir_tab [N_DIR];
  logic [31:0] got_f [9];
  logic [31:0] want_f [9];
  string       fld_name [9] = '{"kind", "reordered", "sent_count", "unique_count",
                                "received_count", "reorder_count", "lost_count",
                                "duplicate_count", "unexpected_count"};
  int          err_cnt = 0;
  int          n_checked = 0;
  int          op_seen [8] = '{default: 0};
  int          cyc = 0;

  packet_sequence_loss_tracker #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // bound the run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYC_LIMIT) begin
      $display("Timeout after %0d cycles, %0d reports still due", cyc, due_reports.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at cycle %0d: %s", cyc, what);
    err_cnt++;
  endtask

  // saturating increment of a total and its window twin
  function automatic void tally(input int c);
    if (tot_cnt[c] != 32'hFFFF_FFFF) tot_cnt[c] = tot_cnt[c] + 32'd1;
    if (win_cnt[c] != 32'hFFFF_FFFF) win_cnt[c] = win_cnt[c] + 32'd1;
  endfunction

  // predict the report for one accepted word; returns 0 when none is due
  function automatic bit score_probe(input in_word_t w, output out_word_t r);
    logic [31:0] off;
    int          idx;
    logic [3:0]  kind;
    logic        reo;
    logic [31:0] shown [N_CNT];
    off  = w.seq - 32'd1;
    idx  = int'(off % DEPTH);
    kind = KIND_FRESH_SEND;
    reo  = 1'b0;
    r    = '0;
    case (w.op)
      OP_SEND: begin
        tally(CNT_SENT);
        if (ring_live[idx] && !ring_acked[idx]) begin
          tally(CNT_LOST);
          kind = KIND_SEND_LOSS;
        end
        ring_seq[idx]   = w.seq;
        ring_live[idx]  = 1'b1;
        ring_acked[idx] = 1'b0;
      end
      OP_RECV: begin
        if (ring_live[idx] && ring_seq[idx] == w.seq) begin
          if (!ring_acked[idx]) begin
            tally(CNT_UNIQUE);
            ring_acked[idx] = 1'b1;
            kind = KIND_FIRST_RECV;
          end else begin
            tally(CNT_DUP);
            kind = KIND_DUPLICATE;
          end
          if (w.seq < top_matched) begin
            tally(CNT_REORDER);
            reo = 1'b1;
          end else begin
            top_matched = w.seq;
          end
        end else if (!ring_live[idx] || w.seq > ring_seq[idx]) begin
          tally(CNT_UNEXP);
          kind = KIND_UNEXPECTED;
        end else begin
          kind = KIND_STALE;
        end
        tally(CNT_RECV);
      end
      OP_LOG: begin
        tally(CNT_UNEXP);
        kind = KIND_LOGGED;
      end
      OP_CLOSE: begin
        kind = KIND_WINDOW;
      end
      OP_FINISH: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (ring_live[i] && !ring_acked[i]) tally(CNT_LOST);
          ring_live[i]  = 1'b0;
          ring_acked[i] = 1'b0;
        end
        kind = KIND_FINAL;
      end
      default: return 1'b0;
    endcase
    // window report shows the window before it is cleared
    for (int i = 0; i < N_CNT; i++) begin
      shown[i] = (w.op == OP_CLOSE) ? win_cnt[i] : tot_cnt[i];
      if (w.op == OP_CLOSE) win_cnt[i] = '0;
    end
    r.kind             = kind;
    r.reordered        = reo;
    r.sent_count       = shown[CNT_SENT];
    r.unique_count     = shown[CNT_UNIQUE];
    r.received_count   = shown[CNT_RECV];
    r.reorder_count    = shown[CNT_REORDER];
    r.lost_count       = shown[CNT_LOST];
    r.duplicate_count  = shown[CNT_DUP];
    r.unexpected_count = shown[CNT_UNEXP];
    return 1'b1;
  endfunction

  // offer one word, hold it until taken, then queue its predicted report
  task automatic offer_word(input in_word_t w, input logic typed, input logic [3:0] k,
                            input logic r);
    out_word_t pred;
    bit        has;
    start   <= 1'b1;
    in_word <= w;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    has = score_probe(w, pred);
    if (has) begin
      if (typed) begin
        pred.kind      = k;
        pred.reordered = r;
      end
      due_reports = {due_reports, pred};
    end
    op_seen[w.op]++;
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (due_reports.size() != 0);
  endtask

  // check every report against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_reports.size() == 0) begin
        report_mismatch($sformatf("report of kind %0d with nothing due", out_word.kind));
      end else begin
        want = due_reports.pop_front();
        got_f  = '{out_word.kind, out_word.reordered, out_word.sent_count,
                   out_word.unique_count, out_word.received_count, out_word.reorder_count,
                   out_word.lost_count, out_word.duplicate_count, out_word.unexpected_count};
        want_f = '{want.kind, want.reordered, want.sent_count, want.unique_count,
                   want.received_count, want.reorder_count, want.lost_count,
                   want.duplicate_count, want.unexpected_count};
        for (int i = 0; i < 9; i++) begin
          if (got_f[i] !== want_f[i])
            report_mismatch($sformatf("report %0d %s got %0h want %0h", n_checked,
                                      fld_name[i], got_f[i], want_f[i]));
        end
        n_checked++;
      end
    end
  end

  initial begin
    in_word_t    w;
    logic [31:0] next_seq;
    logic [31:0] sent_hist [$];
    logic [31:0] pick;
    int          roll;
    int          span;
    bit          gap;

    for (int i = 0; i < DEPTH; i++) begin
      ring_seq[i]   = '0;
      ring_live[i]  = 1'b0;
      ring_acked[i] = 1'b0;
    end
    top_matched = '0;
    for (int i = 0; i < N_CNT; i++) begin
      tot_cnt[i] = '0;
      win_cnt[i] = '0;
    end

    // directed words: slot reuse, aliasing, reorder, number extremes, sweeps
    dir_tab = '{
      '{OP_SEND,   32'd1,          1'b1, KIND_FRESH_SEND, 1'b0},
      '{OP_RECV,   32'd1,          1'b1, KIND_FIRST_RECV, 1'b0},
      '{OP_RECV,   32'd1,          1'b1, KIND_DUPLICATE,  1'b0},
      '{OP_RECV,   32'd2,          1'b1, KIND_UNEXPECTED, 1'b0},
      '{OP_SEND,   32'd1025,       1'b1, KIND_FRESH_SEND, 1'b0},
      '{OP_SEND,   32'd2049,       1'b1, KIND_SEND_LOSS,  1'b0},
      '{OP_RECV,   32'd1025,       1'b1, KIND_STALE,      1'b0},
      '{OP_RECV,   32'd3073,       1'b1, KIND_UNEXPECTED, 1'b0},
      '{OP_SEND,   32'd5,          1'b0, KIND_FRESH_SEND, 1'b0},
      '{OP_SEND,   32'd4,          1'b0, KIND_FRESH_SEND, 1'b0},
      '{OP_RECV,   32'd5,          1'b0, KIND_FIRST_RECV, 1'b0},
      '{OP_RECV,   32'd4,          1'b1, KIND_FIRST_RECV, 1'b1},
      '{OP_SEND,   32'd0,          1'b1, KIND_FRESH_SEND, 1'b0},
      '{OP_SEND,   32'hFFFF_FFFF,  1'b1, KIND_FRESH_SEND, 1'b0},
      '{OP_RECV,   32'hFFFF_FFFF,  1'b1, KIND_FIRST_RECV, 1'b0},
      '{OP_RECV,   32'd0,          1'b1, KIND_FIRST_RECV, 1'b1},
      '{OP_RECV,   32'd2049,       1'b1, KIND_FIRST_RECV, 1'b1},
      '{OP_LOG,    32'd0,          1'b1, KIND_LOGGED,     1'b0},
      '{OP_CLOSE,  32'hFFFF_FFFF,  1'b1, KIND_WINDOW,     1'b0},
      '{OP_CLOSE,  32'd0,          1'b0, KIND_WINDOW,     1'b0},
      '{3'd5,      32'hAAAA_AAAA,  1'b0, KIND_FRESH_SEND, 1'b0},
      '{3'd7,      32'h5555_5555,  1'b0, KIND_FRESH_SEND, 1'b0},
      '{OP_SEND,   32'd6,          1'b0, KIND_FRESH_SEND, 1'b0},
      '{OP_FINISH, 32'd0,          1'b1, KIND_FINAL,      1'b0},
      '{OP_RECV,   32'd6,          1'b1, KIND_UNEXPECTED, 1'b0},
      '{OP_FINISH, 32'hFFFF_FFFF,  1'b1, KIND_FINAL,      1'b0}
    };

    // reset, then the block clears its slots while busy
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if ($urandom_range(0, 99) < 32) hold_off($urandom_range(1, 4));
      w.op  = dir_tab[i].op;
      w.seq = dir_tab[i].seq;
      offer_word(w, dir_tab[i].typed, dir_tab[i].kind, dir_tab[i].reo);
    end

    // random part: mostly in-order sends with matching receives, plus noise
    next_seq = $urandom_range(1, 5000);
    for (int n = 0; n < N_RANDOM; n++) begin
      gap = (n < 150 || n >= 300) && ($urandom_range(0, 99) < 32);
      if (gap) hold_off($urandom_range(1, 6));
      if (n == 300) wait_drained();

      roll = (sent_hist.size() == 0) ? 0 : $urandom_range(0, 99);
      span = sent_hist.size() - 1;
      if (span > 9) span = 9;
      pick = (sent_hist.size() == 0) ? 32'd1
           : sent_hist[sent_hist.size() - 1 - $urandom_range(0, span)];
      w.seq = $urandom();
      if (roll < 36) begin
        w.op     = OP_SEND;
        w.seq    = next_seq;
        next_seq = next_seq + 32'd1;
      end else if (roll < 40) begin
        // same slot as a recent probe
        w.op  = OP_SEND;
        w.seq = pick + DEPTH;
      end else if (roll < 70) begin
        w.op  = OP_RECV;
        w.seq = pick;
      end else if (roll < 74) begin
        w.op  = OP_RECV;
        w.seq = pick - DEPTH;
      end else if (roll < 78) begin
        w.op  = OP_RECV;
        w.seq = pick + DEPTH;
      end else if (roll < 82) begin
        w.op = OP_RECV;
      end else if (roll < 86) begin
        w.op = OP_LOG;
      end else if (roll < 90) begin
        w.op = OP_CLOSE;
      end else if (roll < 91) begin
        w.op = OP_FINISH;
      end else if (roll < 93) begin
        w.op = 3'($urandom_range(5, 7));
      end else if (roll < 96) begin
        // jump the numbering, sometimes right below the wrap
        next_seq = ($urandom_range(0, 1) == 0) ? $urandom()
                 : 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
        w.op     = OP_SEND;
        w.seq    = next_seq;
        next_seq = next_seq + 32'd1;
      end else begin
        w.op = OP_SEND;
      end
      if (w.op == OP_SEND) begin
        sent_hist = {sent_hist, w.seq};
        if (sent_hist.size() > 48) void'(sent_hist.pop_front());
      end
      offer_word(w, 1'b0, KIND_FRESH_SEND, 1'b0);
    end

    // let the last reports drain, then a short tail for stray strobes
    wait_drained();
    repeat (64) @(posedge clk);

    $display("Covered %0d sends, %0d receives, %0d logs, %0d window closes, %0d sweeps, %0d unknown",
             op_seen[OP_SEND], op_seen[OP_RECV], op_seen[OP_LOG], op_seen[OP_CLOSE],
             op_seen[OP_FINISH], op_seen[5] + op_seen[6] + op_seen[7]);
    $display("%0d reports checked field by field, %0d mismatches", n_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
